// File: rtl/hcrm_pkg.sv
// ----------------------------------------------------------------------------
// hcrm_pkg: shared types, constants and the trig table for the ray marcher
// holds the screen geometry, the per-column sine/cosine table and the queue
// entry carried from the classifier to the executor
// ----------------------------------------------------------------------------
package hcrm_pkg;

    localparam int MAP_SIDE_BITS = 8;
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int MAX_DISTANCE  = 99;

    localparam int ADDR_W = 2 * MAP_SIDE_BITS;
    localparam int COL_W  = 9;
    localparam int DIST_W = 7;
    localparam int ROW_W  = 8;
    localparam int TRIG_W = 18;   // signed Q16, range -65536..65536
    localparam int COL_CODES = 1 << COL_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [1:0] REG_VIEWER_X = 2'd0;
    localparam logic [1:0] REG_VIEWER_Y = 2'd1;
    localparam logic [1:0] REG_SCALE    = 2'd2;
    localparam logic [1:0] REG_HORIZON  = 2'd3;

    // input word
    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] map_address;
        logic [7:0]        map_value;
        logic [COL_W-1:0]  column;
        logic [DIST_W-1:0] distance;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [COL_W-1:0] out_column;
        logic [ROW_W-1:0] top_row;
        logic [ROW_W-1:0] bottom_row;
        logic [7:0]       colour;
        logic             last;
    } t_out_word;

    // classified step queued between front and back
    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [DIST_W-1:0] distance;   // zero already folded to one
        logic [ADDR_W-1:0] h_addr;
        logic [ADDR_W-1:0] c_addr;
    } t_step;

    // one trig value per column code
    typedef logic [COL_CODES-1:0][TRIG_W-1:0] t_trig_tab;

    // one-quadrant sine in Q16, f in units of 2^-30 of a quarter turn
    function automatic logic [TRIG_W-1:0] quarter_sine(input logic [31:0] f);
        logic [63:0] th, t2, term;
        logic signed [63:0] sum;
        begin
            th   = (64'(f) * 64'd1686629713) >> 30;
            t2   = (th * th) >> 30;
            term = th;
            sum  = $signed(th);
            for (int k = 1; k <= 5; k++) begin
                term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) sum = sum - $signed(term);
                else            sum = sum + $signed(term);
            end
            quarter_sine = TRIG_W'((64'(sum) + 64'd8192) >> 14);
        end
    endfunction

    function automatic logic signed [TRIG_W-1:0] sine_q16(input logic [33:0] phase);
        logic [1:0]  quad;
        logic [31:0] f;
        logic [TRIG_W-1:0] v;
        begin
            quad = phase[31:30];
            f    = {2'b00, phase[29:0]};
            v    = quad[0] ? quarter_sine(32'h4000_0000 - f) : quarter_sine(f);
            sine_q16 = quad[1] ? $signed(-v) : $signed(v);
        end
    endfunction

    function automatic logic [33:0] col_phase(input logic [COL_W-1:0] col);
        col_phase = 34'((64'(col) << 30) / 64'(SCREEN_WIDTH));
    endfunction

    // table build, evaluated once at elaboration
    function automatic t_trig_tab build_trig_tab(input logic cos_sel);
        t_trig_tab   tab;
        logic [33:0] ph;
        begin
            for (int c = 0; c < COL_CODES; c++) begin
                ph = col_phase(COL_W'(c)) + (cos_sel ? 34'h4000_0000 : 34'h0);
                tab[COL_W'(c)] = sine_q16(ph);
            end
            build_trig_tab = tab;
        end
    endfunction

    localparam t_trig_tab SIN_TAB = build_trig_tab(1'b0);
    localparam t_trig_tab COS_TAB = build_trig_tab(1'b1);

    // constant table lookups, one entry per column code
    function automatic logic signed [TRIG_W-1:0] col_sin(input logic [COL_W-1:0] col);
        col_sin = $signed(SIN_TAB[col]);
    endfunction

    function automatic logic signed [TRIG_W-1:0] col_cos(input logic [COL_W-1:0] col);
        col_cos = $signed(COS_TAB[col]);
    endfunction

endpackage

// File: rtl/hcrm_stream_if.sv
// ----------------------------------------------------------------------------
// hcrm_stream_if: valid/ready channel
// carries one word of type T per accepted handshake
// ----------------------------------------------------------------------------
interface hcrm_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/heightmap_column_ray_marcher.sv
// ----------------------------------------------------------------------------
// heightmap_column_ray_marcher: voxel terrain column ray marcher
// loads a 256x256 height map, then steps column rays and emits screen spans
// ----------------------------------------------------------------------------
// A map write is granted the ram port only after every step accepted
// before it has read the map. A step item is classified over the trig
// table, multiply and address stages and queued; the back end then pops
// it from the queue, does two ram reads, one multiply and a bit-serial
// divide of scale*(256-h) by the distance, and outputs the span, if visible,
// and the sky span when the far plane adds one, stalling while the receiver
// holds off. The divider sets the sustained step rate. Map writes and
// back-end reads share the single ram port, back-end reads first. Reading
// a never-written map entry gives undefined span rows and colour.
module heightmap_column_ray_marcher import hcrm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcrm_stream_if.sink   in_if,
    hcrm_stream_if.source out_if,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    logic [7:0] r_vx, r_vy, r_scale, r_hor;
    logic              wr_req, wr_gnt, q_valid, q_pop, rd_act;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data, rd_data;
    t_step             q_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= 8'd128; r_vy <= 8'd128; r_scale <= 8'd25; r_hor <= 8'd180;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_VIEWER_X: r_vx    <= i_cfg_data;
                REG_VIEWER_Y: r_vy    <= i_cfg_data;
                REG_SCALE:    r_scale <= i_cfg_data;
                REG_HORIZON:  r_hor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign wr_gnt = wr_req && !rd_act;

    hcrm_front u_front (
        .i_clk, .i_rst_n, .in_if,
        .i_viewer_x(r_vx), .i_viewer_y(r_vy),
        .o_wr_req(wr_req), .o_wr_addr(wr_addr), .o_wr_data(wr_data), .i_wr_gnt(wr_gnt),
        .o_q_valid(q_valid), .o_q_data(q_data), .i_q_pop(q_pop)
    );

    hcrm_ram #(.WIDTH(8), .DEPTH(1 << ADDR_W)) u_map (
        .i_clk, .i_we(wr_gnt), .i_addr(rd_act ? rd_addr : wr_addr),
        .i_wdata(wr_data), .o_rdata(rd_data)
    );

    hcrm_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_data(q_data), .o_q_pop(q_pop),
        .i_scale(r_scale), .i_horizon(r_hor),
        .o_rd_act(rd_act), .o_rd_addr(rd_addr), .i_rd_data(rd_data),
        .out_if
    );

    // a write never collides with a back-end read
    a_no_wr_on_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_act |-> !wr_gnt) else $error("map write during read");
    // pop only when the queue holds a step
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    // span rows are never inverted
    a_out_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid |-> out_if.data.top_row <= out_if.data.bottom_row)
        else $error("span inverted");
endmodule

// File: rtl/hcrm_ram.sv
// ----------------------------------------------------------------------------
// hcrm_ram: generic single-port ram
// one write and one read of the same address per cycle, registered read data
// ----------------------------------------------------------------------------
module hcrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: rtl/hcrm_front.sv
// ----------------------------------------------------------------------------
// hcrm_front: accept and classify words
// map writes are turned into ram write requests, steps into map addresses
// pushed to a two-entry queue; pipelined over table, multiply and address
// ----------------------------------------------------------------------------
module hcrm_front import hcrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcrm_stream_if.sink       in_if,
    input  logic [7:0]        i_viewer_x,
    input  logic [7:0]        i_viewer_y,
    // map write request, granted when ram is free
    output logic              o_wr_req,
    output logic [ADDR_W-1:0] o_wr_addr,
    output logic [7:0]        o_wr_data,
    input  logic              i_wr_gnt,
    // queue to back end
    output logic              o_q_valid,
    output t_step             o_q_data,
    input  logic              i_q_pop
);
    // stage 1: table lookup
    logic                      r_s1_v, n_s1_v;
    logic [COL_W-1:0]          r_s1_col;
    logic [DIST_W-1:0]         r_s1_dist;
    logic signed [TRIG_W-1:0]  r_s1_sin, r_s1_cos;
    // stage 2: products
    logic                      r_s2_v;
    logic [COL_W-1:0]          r_s2_col;
    logic [DIST_W-1:0]         r_s2_dist;
    logic signed [TRIG_W+8:0]  r_s2_px, r_s2_py;
    // pending write
    logic                      r_w_v;
    logic [ADDR_W-1:0]         r_w_addr;
    logic [7:0]                r_w_data;
    // queue
    t_step                     r_q [2];
    logic [1:0]                r_cnt;

    logic [DIST_W-1:0] dist_fix;
    logic              s2_push, in_fire, s1_adv, pipe_free;
    logic [MAP_SIDE_BITS-1:0] x_h, y_h, x_c;
    logic signed [TRIG_W+17:0] sx, sy;
    t_step             push_w;

    // queue space counts in-flight steps so the pipe never needs to stall
    assign pipe_free = (32'(r_cnt) + 32'(r_s1_v) + 32'(r_s2_v)) < 2;
    assign in_if.ready = !r_w_v && pipe_free;
    assign in_fire = in_if.valid && in_if.ready;
    assign dist_fix = (in_if.data.distance == '0) ? DIST_W'(1) : in_if.data.distance;
    assign n_s1_v = in_fire && (in_if.data.opcode == OP_STEP);
    assign s1_adv = r_s1_v;

    // map coordinates from viewer plus scaled trig, wrapped to the map side
    assign sx = $signed({2'b00, i_viewer_x, 16'h0}) + (TRIG_W+18)'(r_s2_px);
    assign sy = $signed({2'b00, i_viewer_y, 16'h0}) + (TRIG_W+18)'(r_s2_py);
    assign x_h = sx[16 +: MAP_SIDE_BITS];
    assign y_h = sy[16 +: MAP_SIDE_BITS];
    assign x_c = x_h + MAP_SIDE_BITS'(1 << (MAP_SIDE_BITS - 1));
    assign s2_push = r_s2_v;
    always_comb begin
        push_w.column   = r_s2_col;
        push_w.distance = r_s2_dist;
        push_w.h_addr   = {y_h, x_h};
        push_w.c_addr   = {y_h, x_c};
    end

    // a write waits until older steps have left the front
    assign o_wr_req  = r_w_v && !r_s1_v && !r_s2_v && (r_cnt == 2'd0);
    assign o_wr_addr = r_w_addr;
    assign o_wr_data = r_w_data;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_data  = r_q[0];

    // pipeline and pending write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_w_v  <= 1'b0;
        end else begin
            r_s1_v <= n_s1_v;
            r_s2_v <= s1_adv;
            if (in_fire && in_if.data.opcode == OP_WRITE) r_w_v <= 1'b1;
            else if (i_wr_gnt)                             r_w_v <= 1'b0;
        end
        if (in_fire) begin
            r_s1_col  <= in_if.data.column;
            r_s1_dist <= dist_fix;
            r_s1_sin  <= col_sin(in_if.data.column);
            r_s1_cos  <= col_cos(in_if.data.column);
            r_w_addr  <= in_if.data.map_address;
            r_w_data  <= in_if.data.map_value;
        end
        r_s2_col  <= r_s1_col;
        r_s2_dist <= r_s1_dist;
        r_s2_px   <= r_s1_sin * $signed({1'b0, r_s1_dist});
        r_s2_py   <= r_s1_cos * $signed({1'b0, r_s1_dist});
    end

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(s2_push) - 2'(i_q_pop);
        end
        if (i_q_pop) begin
            r_q[0] <= (r_cnt == 2'd2) ? r_q[1] : push_w;
            if (s2_push) r_q[1] <= push_w;
        end else if (s2_push) begin
            if (r_cnt == 2'd0) r_q[0] <= push_w;
            else               r_q[1] <= push_w;
        end
    end
endmodule

// File: rtl/hcrm_back.sv
// ----------------------------------------------------------------------------
// hcrm_back: execute one ray step
// reads height and colour, divides scale*(256-h) by distance bit-serially,
// clamps, tests against the occlusion row and emits up to two spans
// ----------------------------------------------------------------------------
module hcrm_back import hcrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_step             i_q_data,
    output logic              o_q_pop,
    input  logic [7:0]        i_scale,
    input  logic [7:0]        i_horizon,
    // ram read
    output logic              o_rd_act,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data,
    hcrm_stream_if.source     out_if
);
    localparam int NUM_W = 17;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RDH  = 7'b0000010,
        ST_RDC  = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_EMIT = 7'b0100000,
        ST_SKY  = 7'b1000000
    } t_state;

    t_state              r_st;
    t_step               r_job;
    logic [7:0]          r_h, r_occ;
    logic [NUM_W-1:0]    r_num, r_quo;
    logic [DIST_W:0]     r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_ov;
    t_out_word           r_out;

    logic [DIST_W+1:0]   trial;
    logic signed [NUM_W+1:0] row_s;
    logic [ROW_W-1:0]    row_c;
    logic                is_last, has_span, out_free;

    assign out_free = !r_ov || out_if.ready;
    assign o_q_pop  = (r_st == ST_IDLE) && i_q_valid;
    assign o_rd_act = (r_st == ST_RDH) || (r_st == ST_RDC);
    assign o_rd_addr = (r_st == ST_RDH) ? r_job.h_addr : r_job.c_addr;
    assign out_if.valid = r_ov;
    assign out_if.data  = r_out;

    assign trial = {r_rem, r_num[NUM_W-1]} - {2'b00, r_job.distance};
    assign row_s = $signed({11'd0, i_horizon}) - $signed({2'b00, r_quo});
    assign row_c = (row_s < 0) ? ROW_W'(0)
                 : (row_s > SCREEN_HEIGHT - 1) ? ROW_W'(SCREEN_HEIGHT - 1)
                 : ROW_W'(row_s);
    assign is_last  = 32'(r_job.distance) == MAX_DISTANCE;
    assign has_span = row_c >= r_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_occ <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (out_if.ready) r_ov <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (i_q_valid) begin
                    r_job <= i_q_data;
                    if (i_q_data.distance == DIST_W'(1)) r_occ <= '0;
                    r_st <= ST_RDH;
                end
                ST_RDH: r_st <= ST_RDC;
                ST_RDC: begin
                    r_h  <= i_rd_data;
                    r_st <= ST_MUL;
                end
                ST_MUL: begin
                    r_num <= NUM_W'(i_scale * (9'd256 - {1'b0, r_h}));
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_h   <= i_rd_data;   // colour byte
                    r_st  <= ST_DIV;
                end
                // restoring division, one quotient bit per cycle
                ST_DIV: begin
                    if (trial[DIST_W+1]) begin
                        r_rem <= {r_rem[DIST_W-1:0], r_num[NUM_W-1]};
                        r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                    end else begin
                        r_rem <= trial[DIST_W:0];
                        r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                    end
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(NUM_W - 1)) r_st <= ST_EMIT;
                end
                ST_EMIT: if (out_free) begin
                    if (has_span) begin
                        r_ov <= 1'b1;
                        r_out.out_column <= r_job.column;
                        r_out.top_row    <= ROW_W'(SCREEN_HEIGHT - 1) - row_c;
                        r_out.bottom_row <= ROW_W'(SCREEN_HEIGHT - 1) - r_occ;
                        r_out.colour     <= r_h;
                        r_out.last       <= !is_last;
                        r_occ <= row_c;
                    end
                    r_st <= is_last ? ST_SKY : ST_IDLE;
                end
                ST_SKY: if (out_free) begin
                    r_ov <= 1'b1;
                    r_out.out_column <= r_job.column;
                    r_out.top_row    <= '0;
                    r_out.bottom_row <= ROW_W'(SCREEN_HEIGHT - 1) - r_occ;
                    r_out.colour     <= '0;
                    r_out.last       <= 1'b1;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: dv/tb_heightmap_column_ray_marcher.sv
// ----------------------------------------------------------------------------
// tb_heightmap_column_ray_marcher: span checker for the column ray marcher
// loads the map cells that each step will read plus stray cells, marches columns from
// near to far under several view settings, and compares every span word
// with a fixed-point predictor of the projection and occlusion logic
// ----------------------------------------------------------------------------
module tb_heightmap_column_ray_marcher;
    import hcrm_pkg::*;

    localparam int IDLE_WAIT  = 200;
    localparam int STALL_LIMIT = 5000;
    localparam int ITEM_GOAL  = 850;

    // span predictor and queue of expected span words
    class span_scoreboard;
        logic [7:0] height_map [0:(1<<ADDR_W)-1];
        logic [7:0] occl_row;
        logic [7:0] vx, vy, scale, horizon;
        t_out_word  spans_due[$];
        int         errors;

        function new();
            occl_row = 0;
            vx = 128; vy = 128; scale = 25; horizon = 180;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                REG_VIEWER_X: vx = val;
                REG_VIEWER_Y: vy = val;
                REG_SCALE:    scale = val;
                REG_HORIZON:  horizon = val;
                default: ;
            endcase
        endfunction

        // taylor sine over one quadrant, q30 angle, q16 result
        function longint quad_sine(longint unsigned f);
            longint unsigned th, t2, term;
            longint acc;
            th = (f * 64'd1686629713) >> 30;
            t2 = (th * th) >> 30;
            term = th;
            acc = longint'(th);
            for (int k = 1; k <= 5; k++) begin
                term = ((term * t2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) acc = acc - longint'(term);
                else acc = acc + longint'(term);
            end
            return longint'(($unsigned(acc) + 64'd8192) >> 14);
        endfunction

        function longint wave(longint unsigned phase);
            longint unsigned f;
            longint v;
            f = phase & 64'h3fff_ffff;
            v = phase[30] ? quad_sine(64'h4000_0000 - f) : quad_sine(f);
            return phase[31] ? -v : v;
        endfunction

        function logic [7:0] coord(logic [7:0] viewer, logic [6:0] r, longint trig);
            logic [63:0] v;
            v = (longint'(viewer) <<< 16) + longint'(r) * trig;
            return v[23:16];
        endfunction

        // map cells read by one step: height cell and colour cell
        function void ray_cells(logic [COL_W-1:0] col, logic [DIST_W-1:0] dist_in,
                                output logic [15:0] h_cell, output logic [15:0] c_cell);
            longint unsigned phase;
            logic [6:0] r;
            logic [7:0] x, y;
            r = (dist_in == 0) ? 7'd1 : dist_in;
            phase = (64'(col) << 30) / SCREEN_WIDTH;
            x = coord(vx, r, wave(phase));
            y = coord(vy, r, wave(phase + 64'h4000_0000));
            h_cell = {y, x};
            c_cell = {y, 8'(x + 8'd128)};
        endfunction

        function void note_word(t_in_word w);
            logic [15:0] hc, cc;
            logic [6:0] r;
            int q, row;
            t_out_word s;
            if (w.opcode == OP_WRITE) begin
                height_map[w.map_address] = w.map_value;
                return;
            end
            r = (w.distance == 0) ? 7'd1 : w.distance;
            if (r == 1) occl_row = 0;
            ray_cells(w.column, w.distance, hc, cc);
            q = (int'(scale) * (256 - int'(height_map[hc]))) / int'(r);
            row = int'(horizon) - q;
            if (row < 0) row = 0;
            if (row > SCREEN_HEIGHT - 1) row = SCREEN_HEIGHT - 1;
            if (row >= int'(occl_row)) begin
                s.out_column = w.column;
                s.top_row    = 8'(SCREEN_HEIGHT - 1 - row);
                s.bottom_row = 8'(SCREEN_HEIGHT - 1 - int'(occl_row));
                s.colour     = height_map[cc];
                s.last       = (r != MAX_DISTANCE);
                spans_due.push_back(s);
                occl_row = 8'(row);
            end
            // sky span closes the column
            if (r == MAX_DISTANCE) begin
                s.out_column = w.column;
                s.top_row    = 0;
                s.bottom_row = 8'(SCREEN_HEIGHT - 1 - int'(occl_row));
                s.colour     = 0;
                s.last       = 1;
                spans_due.push_back(s);
            end
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_word(t_out_word w);
            t_out_word e;
            if (spans_due.size() == 0) begin
                report("unexpected span column", w.out_column, -1);
                return;
            end
            e = spans_due.pop_front();
            if (w.out_column !== e.out_column) report("column", w.out_column, e.out_column);
            if (w.top_row !== e.top_row) report("top_row", w.top_row, e.top_row);
            if (w.bottom_row !== e.bottom_row) report("bottom_row", w.bottom_row, e.bottom_row);
            if (w.colour !== e.colour) report("colour", w.colour, e.colour);
            if (w.last !== e.last) report("last", w.last, e.last);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    hcrm_stream_if #(.T(t_in_word))  in_ch ();
    hcrm_stream_if #(.T(t_out_word)) out_ch ();

    heightmap_column_ray_marcher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_if       (in_ch.sink),
        .out_if      (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    span_scoreboard sb;
    logic loaded [0:(1<<ADDR_W)-1];
    int  words_sent;
    int  idle_cycles;
    bit  hold_req;
    bit  burst_mode;

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // monitors: note inputs, check spans, watchdog
    always @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) sb.note_word(in_ch.data);
        if (out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // receiver: stretches of varying readiness plus one long hold-off
    initial begin
        int pct;
        out_ch.ready = 0;
        forever begin
            if (hold_req) begin
                out_ch.ready <= 0;
                repeat (300) @(posedge i_clk);
                hold_req = 0;
            end else begin
                case ($urandom_range(2))
                    0: pct = 100;
                    1: pct = 75;
                    default: pct = 25;
                endcase
                repeat ($urandom_range(64, 8)) begin
                    out_ch.ready <= ($urandom_range(99) < pct);
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_word(t_in_word w);
        int gap;
        in_ch.valid <= 1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_cell(logic [15:0] addr, logic [7:0] val);
        t_in_word w;
        w = t_in_word'({$urandom, $urandom});
        w.opcode = OP_WRITE;
        w.map_address = addr;
        w.map_value = val;
        loaded[addr] = 1;
        send_word(w);
    endtask

    // step one ray, loading any cell it reads that was never written
    task automatic ray_step(logic [COL_W-1:0] col, logic [DIST_W-1:0] dist_in);
        logic [15:0] hc, cc;
        t_in_word w;
        sb.ray_cells(col, dist_in, hc, cc);
        if (!loaded[hc]) write_cell(hc, 8'($urandom));
        if (!loaded[cc]) write_cell(cc, 8'($urandom));
        w = t_in_word'({$urandom, $urandom});
        w.opcode = OP_STEP;
        w.column = col;
        w.distance = dist_in;
        send_word(w);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (sb.spans_due.size() > 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_view(logic [7:0] x, logic [7:0] y, logic [7:0] s, logic [7:0] hz);
        logic [7:0] vals [4];
        vals = '{x, y, s, hz};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1;
            i_cfg_index <= 2'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            sb.set_reg(2'(i), vals[i]);
        end
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // forced height under a ray, written only while the block is idle
    task automatic forced_step(logic [COL_W-1:0] col, logic [DIST_W-1:0] dist_in,
                               logic [7:0] h);
        logic [15:0] hc, cc;
        drain();
        sb.ray_cells(col, dist_in, hc, cc);
        write_cell(hc, h);
        if (!loaded[cc]) write_cell(cc, 8'($urandom));
        ray_step(col, dist_in);
    endtask

    // well-formed column: near to far, ending at the far plane
    task automatic march_column(logic [COL_W-1:0] col);
        int d;
        d = 1;
        while (d < MAX_DISTANCE) begin
            ray_step(col, 7'(d));
            d += $urandom_range(18, 1);
        end
        ray_step(col, 7'(MAX_DISTANCE));
    endtask

    initial begin
        sb = new();
        for (int i = 0; i < (1 << ADDR_W); i++) loaded[i] = 0;
        words_sent = 0;
        idle_cycles = 0;
        hold_req = 0;
        burst_mode = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes of height, column, distance and address
        set_view(128, 128, 25, 180);
        write_cell(16'h0000, 8'h00);
        write_cell(16'hffff, 8'hff);
        forced_step(0, 1, 8'h00);
        forced_step(0, 50, 8'hff);
        forced_step(319, 0, 8'hff);
        forced_step(319, 99, 8'h80);
        forced_step(320, 1, 8'h00);
        forced_step(511, 100, 8'h00);
        forced_step(511, 127, 8'hff);
        forced_step(160, 99, 8'h00);
        drain();
        set_view(0, 0, 255, 199);
        forced_step(0, 1, 8'h00);
        forced_step(300, 99, 8'h01);
        drain();
        set_view(255, 255, 0, 0);
        forced_step(100, 1, 8'hff);
        forced_step(100, 99, 8'h00);
        drain();

        // random phases under a range of view settings
        for (int ph = 0; words_sent < ITEM_GOAL; ph++) begin
            case (ph % 4)
                0: set_view(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(199)));
                1: set_view(1, 254, 255, 199);
                2: set_view(8'($urandom), 8'($urandom), 8'($urandom_range(40)), 100);
                default: set_view(255, 0, 0, 0);
            endcase
            if (ph == 1) begin
                hold_req = 1;
                burst_mode = 1;
            end
            for (int n = 0; n < 4; n++) begin
                if ($urandom_range(9) < 8) begin
                    march_column(9'($urandom_range(SCREEN_WIDTH - 1)));
                end else begin
                    // noise: stray steps and fresh map words anywhere
                    repeat (6) begin
                        if ($urandom_range(1)) ray_step(9'($urandom), 7'($urandom));
                        else begin
                            logic [15:0] a;
                            a = 16'($urandom);
                            if (!loaded[a]) write_cell(a, 8'($urandom));
                        end
                    end
                end
            end
            burst_mode = 0;
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.spans_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/hcrm_pkg.sv
rtl/hcrm_stream_if.sv
rtl/hcrm_ram.sv
rtl/hcrm_front.sv
rtl/hcrm_back.sv
rtl/heightmap_column_ray_marcher.sv
dv/tb_heightmap_column_ray_marcher.sv
